FILE: rtl/core/cartridge_bank_mapper_top_defines.svh
// assertion macros for the cartridge bank mapper
// used by cartridge_bank_mapper_top, expects clk and rst in scope
`ifndef CARTRIDGE_BANK_MAPPER_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CBM_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cbm check failed: implication");
`define CBM_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cbm check failed: next cycle");
`else
`define CBM_ASSERT_IMP(label, cond, prop)
`define CBM_ASSERT_NXT(label, cond, prop)
`endif

`endif

FILE: rtl/core/cbm_pkg.sv
// shared types, codes and helpers of the cartridge bank mapper
// no dependencies
package cbm_pkg;

  localparam int MAX_PRG_BANKS = 32;
  localparam int MAX_CHR_BANKS = 32;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int BANK_W  = 5;
  localparam int COUNT_W = 6;
  localparam int KIND_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PRG_OFF_W = 19;
  localparam int SRAM_OFF_W = 13;
  localparam int MIRROR_W = 4;

  localparam logic [COUNT_W-1:0] MAX_PRG_EFF = COUNT_W'(MAX_PRG_BANKS);
  localparam logic [COUNT_W-1:0] MAX_CHR_EFF = COUNT_W'(MAX_CHR_BANKS);

  // mapper kinds
  localparam logic [KIND_W-1:0] KIND_FIXED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SERIAL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PRG    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_AXROM  = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT   = 2'd2;

  // serial loader target registers, chosen by address bits 14:13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // bank window slots
  localparam logic [1:0] SLOT_PRG_LOW  = 2'd0;
  localparam logic [1:0] SLOT_PRG_HIGH = 2'd1;
  localparam logic [1:0] SLOT_CHR_LOW  = 2'd2;
  localparam logic [1:0] SLOT_CHR_HIGH = 2'd3;

  localparam logic [BANK_W-1:0] CONTROL_RESET = 5'h0C;
  localparam logic [BANK_W-1:0] PRG_MODE_BITS = 5'h0C;
  localparam logic [MIRROR_W-1:0] MIRROR_VERTICAL = 4'hA;

  // prg bank modes of the serial mapper control register
  localparam logic [1:0] PRG_MODE_FIX_LOW = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [BANK_W-1:0] control;
    logic [BANK_W-1:0] chr_first;
    logic [BANK_W-1:0] chr_second;
    logic [BANK_W-1:0] prg;
  } mmc1_regs_t;

  // zero counts as one bank, oversize saturates
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] v,
                                                   input logic [COUNT_W-1:0] max_v);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [MIRROR_W-1:0] mirror_map(input logic [1:0] code);
    logic [MIRROR_W-1:0] r;
    unique case (code)
      2'd0: r = 4'h0;
      2'd1: r = 4'hF;
      2'd2: r = 4'hA;
      2'd3: r = 4'hC;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/cbm_mod_unit.sv
// shared restoring remainder unit, one dividend bit per cycle
// depends on cbm_pkg
module cbm_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbm_pkg::DATA_W-1:0]    dividend,
  input  logic [cbm_pkg::COUNT_W-1:0]   divisor,
  output logic                          done,
  output logic [cbm_pkg::BANK_W-1:0]    remainder
);
  import cbm_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  step_cnt;
  logic [DATA_W-1:0]     num_shift;
  logic [COUNT_W-1:0]    div_q;
  logic [BANK_W:0]       trial;
  logic [BANK_W:0]       diff;
  logic [BANK_W-1:0]     rem_next;

  always_comb begin
    trial = {remainder, num_shift[DATA_W-1]};
    diff  = trial - {1'b0, div_q[BANK_W-1:0]} - {div_q[BANK_W], {BANK_W{1'b0}}};
    if (trial >= div_q) begin
      rem_next = diff[BANK_W-1:0];
    end else begin
      rem_next = trial[BANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step_cnt  <= '0;
        num_shift <= dividend;
        div_q     <= divisor;
        remainder <= '0;
      end else if (busy) begin
        remainder <= rem_next;
        num_shift <= {num_shift[DATA_W-2:0], 1'b0};
        step_cnt  <= step_cnt + DIV_CNT_W'(1);
        if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/cbm_serial_loader.sv
// five-write serial loader and its four target registers
// depends on cbm_pkg
module cbm_serial_loader (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [1:0]                 reg_sel,
  input  logic [cbm_pkg::DATA_W-1:0] data,
  output cbm_pkg::mmc1_regs_t        regs,
  output logic                       apply
);
  import cbm_pkg::*;

  logic [BANK_W-1:0] shift_reg;
  logic [2:0]        bit_count;
  logic [BANK_W-1:0] shifted;

  always_comb begin
    shifted = shift_reg | (BANK_W'(data[0]) << bit_count);
    apply   = load && (data[DATA_W-1] || (bit_count == 3'd4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg       <= '0;
      bit_count       <= '0;
      regs.control    <= CONTROL_RESET;
      regs.chr_first  <= '0;
      regs.chr_second <= '0;
      regs.prg        <= '0;
    end else if (load) begin
      if (data[DATA_W-1]) begin
        // loader reset, forces fixed-high prg mode
        regs.control <= regs.control | PRG_MODE_BITS;
        shift_reg    <= '0;
        bit_count    <= '0;
      end else if (bit_count == 3'd4) begin
        unique case (reg_sel)
          SEL_CONTROL: regs.control    <= shifted;
          SEL_CHR0:    regs.chr_first  <= shifted;
          SEL_CHR1:    regs.chr_second <= shifted;
          SEL_PRG:     regs.prg        <= shifted;
        endcase
        shift_reg <= '0;
        bit_count <= '0;
      end else begin
        shift_reg <= shifted;
        bit_count <= bit_count + 3'd1;
      end
    end
  end

endmodule

FILE: rtl/core/cartridge_bank_mapper_top.sv
// an access is captured, then passes the loader, plan and pick states to the finish state;
// each bank index wrapped (at most 4) adds a pass through the 8-step shared remainder unit
// one access at a time; the next input transfer is taken only once the result is
// registered; configuration writes are always accepted
// rst is synchronous: windows return to prg banks 0 / 1, chr banks 0 / 1, vertical
// mirroring, loader cleared, control 0x0C, kind 0, both counts 2
module cartridge_bank_mapper_top (
  input  logic                             clk,
  input  logic                             rst,
  // access channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cbm_pkg::ADDR_W-1:0]       address,
  input  logic                             command,
  input  logic [cbm_pkg::DATA_W-1:0]       write_data,
  input  logic [cbm_pkg::DATA_W-1:0]       rom_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             sram_select,
  output logic [cbm_pkg::SRAM_OFF_W-1:0]   sram_offset,
  output logic [cbm_pkg::PRG_OFF_W-1:0]    prg_offset,
  output logic [cbm_pkg::BANK_W-1:0]       chr_low_bank,
  output logic [cbm_pkg::BANK_W-1:0]       chr_high_bank,
  output logic [cbm_pkg::MIRROR_W-1:0]     nametable_select,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbm_pkg::COUNT_W-1:0]      cfg_data
);
  import cbm_pkg::*;

`include "cartridge_bank_mapper_top_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADER,
    S_PLAN,
    S_PICK,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [KIND_W-1:0]  mapper_kind;
  logic [COUNT_W-1:0] prg_count;
  logic [COUNT_W-1:0] chr_count;
  logic [COUNT_W-1:0] prg_eff;
  logic [COUNT_W-1:0] chr_eff;
  logic [COUNT_W-1:0] cfg_prg_eff;
  logic [COUNT_W-1:0] cfg_chr_eff;

  // captured access
  logic [ADDR_W-1:0] it_addr;
  logic              it_cmd;
  logic [DATA_W-1:0] it_data;
  logic [DATA_W-1:0] it_rom;
  logic              hi_write;

  // bank windows, indexed by slot
  logic [BANK_W-1:0]   win [4];
  logic [MIRROR_W-1:0] mirror_select;

  // serial loader
  mmc1_regs_t mmc1_regs;
  logic       loader_load;
  logic       loader_apply;
  logic       apply_q;

  // job plan: which windows still need a wrapped index
  logic [3:0]        plan_mask;
  logic [DATA_W-1:0] plan_div [4];
  logic [3:0]        plan_set;
  logic [BANK_W-1:0] plan_val [4];
  logic              plan_mirror_en;
  logic [MIRROR_W-1:0] plan_mirror;
  logic [3:0]        job_mask;
  logic [DATA_W-1:0] job_div [4];
  logic [1:0]        pick_slot;
  logic [1:0]        cur_slot;

  // shared remainder unit
  logic              mod_start;
  logic [COUNT_W-1:0] mod_divisor;
  logic              mod_done;
  logic [BANK_W-1:0] mod_rem;

  // result
  logic [BANK_W-1:0]    prg_bank;
  logic [PRG_OFF_W-1:0] prg_off_calc;
  logic                 in_sram;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign hi_write  = it_cmd && it_addr[ADDR_W-1];

  always_comb begin
    prg_eff = eff_count(prg_count, MAX_PRG_EFF);
    chr_eff = eff_count(chr_count, MAX_CHR_EFF);
    // counts as they stand after the current configuration write
    cfg_prg_eff = (cfg_index == CFG_PRG_COUNT) ? eff_count(cfg_data, MAX_PRG_EFF) : prg_eff;
    cfg_chr_eff = (cfg_index == CFG_CHR_COUNT) ? eff_count(cfg_data, MAX_CHR_EFF) : chr_eff;
  end

  assign loader_load = (state == S_LOADER) && hi_write && (mapper_kind == KIND_SERIAL);

  cbm_serial_loader u_loader (
    .clk     (clk),
    .rst     (rst),
    .load    (loader_load),
    .reg_sel (it_addr[14:13]),
    .data    (it_data),
    .regs    (mmc1_regs),
    .apply   (loader_apply)
  );

  // decide which windows change and what each is set to or wrapped from
  always_comb begin
    plan_mask      = '0;
    plan_set       = '0;
    plan_mirror_en = 1'b0;
    plan_mirror    = '0;
    for (int i = 0; i < 4; i++) begin
      plan_div[i] = '0;
      plan_val[i] = '0;
    end
    if (hi_write) begin
      unique case (mapper_kind)
        KIND_AXROM: begin
          // 32K bank: two consecutive 16K banks
          plan_mask[SLOT_PRG_LOW]  = 1'b1;
          plan_mask[SLOT_PRG_HIGH] = 1'b1;
          plan_div[SLOT_PRG_LOW]   = {4'b0, it_data[2:0], 1'b0};
          plan_div[SLOT_PRG_HIGH]  = {4'b0, it_data[2:0], 1'b1};
          plan_mirror_en = 1'b1;
          plan_mirror    = it_data[4] ? 4'hF : 4'h0;
        end
        KIND_PRG: begin
          plan_mask[SLOT_PRG_LOW] = 1'b1;
          plan_div[SLOT_PRG_LOW]  = it_data;
        end
        KIND_CHR: begin
          // bus conflict: cpu data anded with the rom byte
          plan_mask[SLOT_CHR_LOW]  = 1'b1;
          plan_mask[SLOT_CHR_HIGH] = 1'b1;
          plan_div[SLOT_CHR_LOW]   = {5'b0, it_data[1:0] & it_rom[1:0], 1'b0};
          plan_div[SLOT_CHR_HIGH]  = {5'b0, it_data[1:0] & it_rom[1:0], 1'b1};
        end
        KIND_SERIAL: begin
          if (apply_q) begin
            plan_mirror_en = 1'b1;
            plan_mirror    = mirror_map(mmc1_regs.control[1:0]);
            plan_mask[SLOT_CHR_LOW]  = 1'b1;
            plan_mask[SLOT_CHR_HIGH] = 1'b1;
            if (mmc1_regs.control[4]) begin
              // two separate 4K chr banks
              plan_div[SLOT_CHR_LOW]  = {3'b0, mmc1_regs.chr_first};
              plan_div[SLOT_CHR_HIGH] = {3'b0, mmc1_regs.chr_second};
            end else begin
              // one 8K chr bank
              plan_div[SLOT_CHR_LOW]  = {3'b0, mmc1_regs.chr_first[4:1], 1'b0};
              plan_div[SLOT_CHR_HIGH] = {3'b0, mmc1_regs.chr_first[4:1], 1'b1};
            end
            unique case (mmc1_regs.control[3:2])
              PRG_MODE_FIX_LOW: begin
                plan_set[SLOT_PRG_LOW]   = 1'b1;
                plan_val[SLOT_PRG_LOW]   = '0;
                plan_mask[SLOT_PRG_HIGH] = 1'b1;
                plan_div[SLOT_PRG_HIGH]  = {4'b0, mmc1_regs.prg[3:0]};
              end
              PRG_MODE_FIX_HIGH: begin
                plan_mask[SLOT_PRG_LOW] = 1'b1;
                plan_div[SLOT_PRG_LOW]  = {4'b0, mmc1_regs.prg[3:0]};
                plan_set[SLOT_PRG_HIGH] = 1'b1;
                plan_val[SLOT_PRG_HIGH] = BANK_W'(prg_eff - COUNT_W'(1));
              end
              default: begin
                // 32K mode
                plan_mask[SLOT_PRG_LOW]  = 1'b1;
                plan_mask[SLOT_PRG_HIGH] = 1'b1;
                plan_div[SLOT_PRG_LOW]   = {4'b0, mmc1_regs.prg[3:1], 1'b0};
                plan_div[SLOT_PRG_HIGH]  = {4'b0, mmc1_regs.prg[3:1], 1'b1};
              end
            endcase
          end
        end
        default: begin
          // fixed mapping, nothing switches
        end
      endcase
    end
  end

  // lowest pending slot goes first
  always_comb begin
    priority if (job_mask[0]) begin
      pick_slot = 2'd0;
    end else if (job_mask[1]) begin
      pick_slot = 2'd1;
    end else if (job_mask[2]) begin
      pick_slot = 2'd2;
    end else begin
      pick_slot = 2'd3;
    end
  end

  assign mod_start   = (state == S_PICK) && (job_mask != '0);
  assign mod_divisor = (pick_slot == SLOT_CHR_LOW || pick_slot == SLOT_CHR_HIGH) ? chr_eff
                                                                                  : prg_eff;

  cbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (job_div[pick_slot]),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // result mapping of the captured address
  always_comb begin
    in_sram  = (it_addr[15:13] == 3'b011);
    prg_bank = it_addr[14] ? win[SLOT_PRG_HIGH] : win[SLOT_PRG_LOW];
    if (in_sram) begin
      prg_off_calc = '0;
    end else if (it_addr[15]) begin
      prg_off_calc = {prg_bank, it_addr[13:0]};
    end else begin
      prg_off_calc = {{BANK_W{1'b0}}, it_addr[13:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      mapper_kind        <= KIND_FIXED;
      prg_count          <= COUNT_W'(2);
      chr_count          <= COUNT_W'(2);
      win[SLOT_PRG_LOW]  <= '0;
      win[SLOT_PRG_HIGH] <= BANK_W'(1);
      win[SLOT_CHR_LOW]  <= '0;
      win[SLOT_CHR_HIGH] <= BANK_W'(1);
      mirror_select      <= MIRROR_VERTICAL;
      job_mask           <= '0;
      apply_q            <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            it_addr <= address;
            it_cmd  <= command;
            it_data <= write_data;
            it_rom  <= rom_byte;
            state   <= S_LOADER;
          end
        end
        S_LOADER: begin
          // loader registers settle here, the plan reads them next
          apply_q <= loader_apply;
          state   <= S_PLAN;
        end
        S_PLAN: begin
          job_mask <= plan_mask;
          for (int i = 0; i < 4; i++) begin
            job_div[i] <= plan_div[i];
            if (plan_set[i]) begin
              win[i] <= plan_val[i];
            end
          end
          if (plan_mirror_en) begin
            mirror_select <= plan_mirror;
          end
          state <= S_PICK;
        end
        S_PICK: begin
          if (job_mask == '0) begin
            state <= S_FINISH;
          end else begin
            cur_slot <= pick_slot;
            state    <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mod_done) begin
            win[cur_slot]      <= mod_rem;
            job_mask[cur_slot] <= 1'b0;
            state              <= S_PICK;
          end
        end
        S_FINISH: begin
          // output register frees up when the previous result transfers
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            sram_select      <= in_sram;
            sram_offset      <= it_addr[SRAM_OFF_W-1:0];
            prg_offset       <= prg_off_calc;
            chr_low_bank     <= win[SLOT_CHR_LOW];
            chr_high_bank    <= win[SLOT_CHR_HIGH];
            nametable_select <= mirror_select;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // configuration writes, as after loading a cartridge for the counts
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAPPER_KIND: begin
            mapper_kind <= cfg_data[KIND_W-1:0];
          end
          CFG_PRG_COUNT, CFG_CHR_COUNT: begin
            if (cfg_index == CFG_PRG_COUNT) begin
              prg_count <= cfg_data;
            end else begin
              chr_count <= cfg_data;
            end
            win[SLOT_PRG_LOW]  <= '0;
            win[SLOT_PRG_HIGH] <= BANK_W'(cfg_prg_eff - COUNT_W'(1));
            win[SLOT_CHR_LOW]  <= '0;
            win[SLOT_CHR_HIGH] <= (cfg_chr_eff > COUNT_W'(1)) ? BANK_W'(1) : BANK_W'(0);
          end
          default: begin
            // index beyond the register list is dropped
          end
        endcase
      end
    end
  end

  // a remainder only comes back while the sequencer waits for it
  `CBM_ASSERT_IMP(a_done_in_wait, mod_done, state == S_WAIT)
  // an empty job list goes straight to the result
  `CBM_ASSERT_NXT(a_empty_plan_finish, state == S_PICK && job_mask == 4'b0, state == S_FINISH)
  // a bank count write restores both low windows to bank zero
  `CBM_ASSERT_NXT(a_count_write_init,
                  cfg_valid && (cfg_index == CFG_PRG_COUNT || cfg_index == CFG_CHR_COUNT),
                  win[SLOT_PRG_LOW] == 5'd0 && win[SLOT_CHR_LOW] == 5'd0)

endmodule

FILE: verif/cartridge_bank_mapper_top_tb.sv
// testbench for cartridge_bank_mapper_top: directed and random cpu bus accesses
// over several mapper kinds and rom sizes, checked against an in-bench mapping model
// depends on cbm_pkg and cartridge_bank_mapper_top
`timescale 1ns / 100ps

module cartridge_bank_mapper_top_tb;
  import cbm_pkg::*;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // kinds 4..6 have no bank logic and behave as fixed
  localparam logic [KIND_W-1:0] KIND_PLAIN_LO = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PLAIN_HI = 3'd6;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 144;
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              wr;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] rom;
  } access_t;

  typedef struct packed {
    logic                  sram_hit;
    logic [SRAM_OFF_W-1:0] sram_off;
    logic [PRG_OFF_W-1:0]  prg_off;
    logic [BANK_W-1:0]     chr_lo;
    logic [BANK_W-1:0]     chr_hi;
    logic [MIRROR_W-1:0]   screens;
  } map_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     address = '0;
  logic                  command = 1'b0;
  logic [DATA_W-1:0]     write_data = '0;
  logic [DATA_W-1:0]     rom_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  sram_select;
  logic [SRAM_OFF_W-1:0] sram_offset;
  logic [PRG_OFF_W-1:0]  prg_offset;
  logic [BANK_W-1:0]     chr_low_bank;
  logic [BANK_W-1:0]     chr_high_bank;
  logic [MIRROR_W-1:0]   nametable_select;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COUNT_W-1:0]    cfg_data = '0;

  cartridge_bank_mapper_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .address          (address),
    .command          (command),
    .write_data       (write_data),
    .rom_byte         (rom_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .sram_select      (sram_select),
    .sram_offset      (sram_offset),
    .prg_offset       (prg_offset),
    .chr_low_bank     (chr_low_bank),
    .chr_high_bank    (chr_high_bank),
    .nametable_select (nametable_select),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // accesses waiting for the driver, and mappings waiting for the block
  access_t pending_accesses[$];
  map_t    due_mappings[$];

  int error_count = 0;
  int posted = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 45;
  logic sink_hold = 1'b0;
  event start_hold;

  // ---------------------------------------------------------------------------
  // mapping model: configuration copy and bank state as after reset
  // ---------------------------------------------------------------------------
  logic [KIND_W-1:0]   kind_cfg = KIND_FIXED;
  logic [COUNT_W-1:0]  prg_count_cfg = 6'd2;
  logic [COUNT_W-1:0]  chr_count_cfg = 6'd2;
  logic [BANK_W-1:0]   prg_lo = 5'd0;
  logic [BANK_W-1:0]   prg_hi = 5'd1;
  logic [BANK_W-1:0]   chr_lo = 5'd0;
  logic [BANK_W-1:0]   chr_hi = 5'd1;
  logic [MIRROR_W-1:0] screens = MIRROR_VERTICAL;
  logic [BANK_W-1:0]   shift_reg = '0;
  logic [2:0]          shift_cnt = '0;
  logic [BANK_W-1:0]   ctrl_reg = CONTROL_RESET;
  logic [BANK_W-1:0]   chr_sel0 = '0;
  logic [BANK_W-1:0]   chr_sel1 = '0;
  logic [BANK_W-1:0]   prg_sel = '0;

  // zero banks act as one, oversize saturates at the build maximum
  function automatic int bank_total(logic [COUNT_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic [BANK_W-1:0] wrap_prg(int idx);
    return BANK_W'(idx % bank_total(prg_count_cfg, MAX_PRG_BANKS));
  endfunction

  function automatic logic [BANK_W-1:0] wrap_chr(int idx);
    return BANK_W'(idx % bank_total(chr_count_cfg, MAX_CHR_BANKS));
  endfunction

  // a new rom size puts the windows back to first / last prg and chr 0 / 1
  function automatic void reset_windows();
    prg_lo = '0;
    prg_hi = BANK_W'(bank_total(prg_count_cfg, MAX_PRG_BANKS) - 1);
    chr_lo = wrap_chr(0);
    chr_hi = wrap_chr(1);
  endfunction

  // bank writes first, then the mapping of the same address
  function automatic map_t map_access(access_t acc);
    map_t res;
    int   step;
    int   chr_base;
    logic reload;
    reload = 1'b0;
    if (acc.wr && acc.addr[15]) begin
      case (kind_cfg)
        KIND_AXROM: begin
          step = int'(acc.data[2:0]) * 2;
          prg_lo = wrap_prg(step);
          prg_hi = wrap_prg(step + 1);
          screens = acc.data[4] ? 4'hF : 4'h0;
        end
        KIND_PRG: prg_lo = wrap_prg(int'(acc.data));
        KIND_CHR: begin
          // bus conflict: the rom byte drives the same lines
          step = int'(acc.data[1:0] & acc.rom[1:0]) * 2;
          chr_lo = wrap_chr(step);
          chr_hi = wrap_chr(step + 1);
        end
        KIND_SERIAL: begin
          if (acc.data[7]) begin
            ctrl_reg = ctrl_reg | PRG_MODE_BITS;
            reload = 1'b1;
          end else begin
            shift_reg = shift_reg | (BANK_W'(acc.data[0]) << shift_cnt);
            shift_cnt = shift_cnt + 3'd1;
            if (shift_cnt == 3'd5) begin
              reload = 1'b1;
              case (acc.addr[14:13])
                SEL_CONTROL: ctrl_reg = shift_reg;
                SEL_CHR0:    chr_sel0 = shift_reg;
                SEL_CHR1:    chr_sel1 = shift_reg;
                default:     prg_sel = shift_reg;
              endcase
            end
          end
          if (reload) begin
            shift_reg = '0;
            shift_cnt = '0;
            case (ctrl_reg[1:0])
              2'd0:    screens = 4'h0;
              2'd1:    screens = 4'hF;
              2'd2:    screens = MIRROR_VERTICAL;
              default: screens = 4'hC;
            endcase
            if (ctrl_reg[4]) begin
              chr_lo = wrap_chr(int'(chr_sel0));
              chr_hi = wrap_chr(int'(chr_sel1));
            end else begin
              chr_base = int'(chr_sel0 & 5'h1E);
              chr_lo = wrap_chr(chr_base);
              chr_hi = wrap_chr(chr_base + 1);
            end
            case (ctrl_reg[3:2])
              PRG_MODE_FIX_LOW: begin
                prg_lo = wrap_prg(0);
                prg_hi = wrap_prg(int'(prg_sel & 5'h0F));
              end
              PRG_MODE_FIX_HIGH: begin
                prg_lo = wrap_prg(int'(prg_sel & 5'h0F));
                prg_hi = BANK_W'(bank_total(prg_count_cfg, MAX_PRG_BANKS) - 1);
              end
              default: begin
                prg_lo = wrap_prg(int'(prg_sel & 5'h0E));
                prg_hi = wrap_prg(int'(prg_sel & 5'h0E) + 1);
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    res.sram_hit = (acc.addr[15:13] == 3'b011);
    res.sram_off = acc.addr[12:0];
    if (res.sram_hit) begin
      res.prg_off = '0;
    end else if (acc.addr[15]) begin
      res.prg_off = PRG_OFF_W'(int'(acc.addr[14] ? prg_hi : prg_lo) * 32'h4000
                               + int'(acc.addr[13:0]));
    end else begin
      res.prg_off = PRG_OFF_W'(acc.addr[13:0]);
    end
    res.chr_lo = chr_lo;
    res.chr_hi = chr_hi;
    res.screens = screens;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, several times the slowest legal run
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // access driver: one transfer per handshake, prediction at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_accesses
    access_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_mappings.push_back(map_access({address, command, write_data, rom_byte}));
      end
      // a held item stays put until its transfer
      if (!in_valid || in_ready) begin
        if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_accesses.pop_front();
          address    <= nxt.addr;
          command    <= nxt.wr;
          write_data <= nxt.data;
          rom_byte   <= nxt.rom;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: each transfer against the oldest predicted mapping
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    map_t seen;
    map_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {sram_select, sram_offset, prg_offset, chr_low_bank, chr_high_bank,
                nametable_select};
        if (due_mappings.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result with nothing outstanding, prg %h chr %h/%h nt %h",
                     $realtime, seen.prg_off, seen.chr_lo, seen.chr_hi, seen.screens);
        end else begin
          want = due_mappings.pop_front();
          if (seen.sram_hit !== want.sram_hit || seen.sram_off !== want.sram_off ||
              seen.prg_off !== want.prg_off || seen.chr_lo !== want.chr_lo ||
              seen.chr_hi !== want.chr_hi || seen.screens !== want.screens) begin
            error_count++;
            if (error_count <= 10)
              $display({"%0t: mapping mismatch, expected sram %b/%h prg %h chr %h/%h nt %h,",
                        " got sram %b/%h prg %h chr %h/%h nt %h"}, $realtime,
                       want.sram_hit, want.sram_off, want.prg_off, want.chr_lo,
                       want.chr_hi, want.screens, seen.sram_hit, seen.sram_off,
                       seen.prg_off, seen.chr_lo, seen.chr_hi, seen.screens);
          end
        end
      end
      out_ready <= !sink_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, so the block fills and stalls its input
  initial begin : sink_backpressure
    forever begin
      @(start_hold);
      @(posedge clk);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic post(logic [ADDR_W-1:0] addr, logic wr, logic [DATA_W-1:0] data,
                      logic [DATA_W-1:0] rom);
    pending_accesses.push_back({addr, wr, data, rom});
    posted++;
  endtask

  // register transfer while the block is idle, model follows at the handshake
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAPPER_KIND: kind_cfg = value[KIND_W-1:0];
      CFG_PRG_COUNT: begin
        prg_count_cfg = value;
        reset_windows();
      end
      CFG_CHR_COUNT: begin
        chr_count_cfg = value;
        reset_windows();
      end
      default: ;
    endcase
  endtask

  // sender pause: nothing queued, nothing held, every mapping returned
  task automatic wait_idle();
    @(posedge clk);
    while (pending_accesses.size() != 0 || in_valid || due_mappings.size() != 0)
      @(posedge clk);
  endtask

  // spread over the bus regions, with the window edges picked often
  function automatic logic [ADDR_W-1:0] random_address();
    logic [ADDR_W-1:0] a;
    case ($urandom_range(0, 4))
      0: a = ADDR_W'($urandom_range(0, 16'h5FFF));
      1: a = ADDR_W'($urandom_range(16'h6000, 16'h7FFF));
      2: a = ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
      3: a = ADDR_W'($urandom);
      default: begin
        case ($urandom_range(0, 7))
          0: a = 16'h0000;
          1: a = 16'h5FFF;
          2: a = 16'h6000;
          3: a = 16'h7FFF;
          4: a = 16'h8000;
          5: a = 16'hBFFF;
          6: a = 16'hC000;
          default: a = 16'hFFFF;
        endcase
      end
    endcase
    return a;
  endfunction

  function automatic logic [COUNT_W-1:0] random_count();
    if ($urandom_range(0, 1) != 0) return COUNT_W'($urandom_range(1, 32));
    return COUNT_W'($urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int phase_start;
    int pick;
    logic [1:0] target;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] rom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset setup, fixed mapping: every region edge, writes change nothing
    post(16'h0000, 1'b0, 8'h00, 8'h00);
    post(16'h5FFF, 1'b0, 8'hFF, 8'hFF);
    post(16'h6000, 1'b0, 8'h00, 8'h00);
    post(16'h7FFF, 1'b0, 8'h00, 8'h00);
    post(16'h8000, 1'b0, 8'h00, 8'h00);
    post(16'hBFFF, 1'b0, 8'h00, 8'h00);
    post(16'hC000, 1'b0, 8'h00, 8'h00);
    post(16'hFFFF, 1'b0, 8'h00, 8'h00);
    post(16'h8000, 1'b1, 8'hFF, 8'hFF);
    post(16'h7FFF, 1'b1, 8'h80, 8'hFF);
    wait_idle();

    // 32k switch with saturated prg size and a zero chr size
    write_register(CFG_MAPPER_KIND, {3'b000, KIND_AXROM});
    write_register(CFG_PRG_COUNT, 6'd63);
    write_register(CFG_CHR_COUNT, 6'd0);
    post(16'hFFFF, 1'b1, 8'h17, 8'h00);
    post(16'hC000, 1'b0, 8'h00, 8'h00);
    post(16'h8000, 1'b1, 8'hE8, 8'hFF);
    wait_idle();

    // chr switch, bus conflict masks the written value
    write_register(CFG_MAPPER_KIND, {3'b111, KIND_CHR});
    write_register(CFG_CHR_COUNT, 6'd32);
    post(16'h8000, 1'b1, 8'hFF, 8'h02);
    post(16'hFFFF, 1'b1, 8'h01, 8'hFE);
    wait_idle();

    // prg switch, bank index wraps on the largest rom
    write_register(CFG_MAPPER_KIND, {3'b010, KIND_PRG});
    write_register(CFG_PRG_COUNT, 6'd32);
    post(16'hC000, 1'b1, 8'hFF, 8'hFF);
    wait_idle();

    // serial loader: reset write, then five bits into the prg register
    write_register(CFG_MAPPER_KIND, {3'b101, KIND_SERIAL});
    post(16'h8000, 1'b1, 8'h80, 8'h00);
    post(16'hE000, 1'b1, 8'h01, 8'h00);
    post(16'hE000, 1'b1, 8'h7E, 8'h00);
    post(16'hE000, 1'b1, 8'h01, 8'h00);
    post(16'hE000, 1'b1, 8'h01, 8'h00);
    post(16'hE000, 1'b1, 8'h00, 8'h00);
    post(16'h8000, 1'b0, 8'h00, 8'h00);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      // sender / receiver idling swaps after a third, stops after two thirds
      if (phase == PHASES / 3) begin
        send_idle_pct <= 45;
        recv_idle_pct <= 26;
      end else if (phase == 2 * PHASES / 3) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end

      // rom sizes, extremes first; every third phase keeps the previous sizes
      // so loader state carries across a kind change
      case (phase)
        0: begin
          write_register(CFG_PRG_COUNT, 6'd1);
          write_register(CFG_CHR_COUNT, 6'd32);
        end
        1: begin
          write_register(CFG_PRG_COUNT, 6'd32);
          write_register(CFG_CHR_COUNT, 6'd0);
        end
        3: begin
          write_register(CFG_PRG_COUNT, 6'd0);
          write_register(CFG_CHR_COUNT, 6'd63);
        end
        4: begin
          write_register(CFG_PRG_COUNT, 6'd63);
          write_register(CFG_CHR_COUNT, 6'd1);
        end
        6: begin
          write_register(CFG_PRG_COUNT, 6'd33);
          write_register(CFG_CHR_COUNT, 6'd2);
        end
        default: begin
          if (phase % 3 != 2) begin
            write_register(CFG_PRG_COUNT, random_count());
            write_register(CFG_CHR_COUNT, random_count());
          end
        end
      endcase
      if (phase == 3) write_register(CFG_SPARE, COUNT_W'($urandom));

      case (phase % 6)
        0, 4: kind = KIND_SERIAL;
        1: kind = KIND_PRG;
        2: kind = KIND_CHR;
        3: kind = KIND_AXROM;
        default: kind = (phase == 5) ? KIND_FIXED
                                     : KIND_W'($urandom_range(KIND_PLAIN_LO, KIND_PLAIN_HI));
      endcase
      // upper data bits are outside the kind field and must not matter
      write_register(CFG_MAPPER_KIND, {3'($urandom_range(0, 7)), kind});

      phase_start = posted;
      while (posted - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (kind == KIND_SERIAL) begin
          if (pick < 60) begin
            // well-formed load, sometimes after a loader reset, reads mixed in
            if ($urandom_range(0, 3) == 0)
              post({1'b1, 15'($urandom)}, 1'b1, 8'h80 | 8'($urandom), 8'($urandom));
            target = 2'($urandom_range(0, 3));
            for (int k = 0; k < 5; k++) begin
              if ($urandom_range(0, 3) == 0)
                post(random_address(), 1'b0, 8'($urandom), 8'($urandom));
              post({1'b1, target, 13'($urandom)}, 1'b1, {1'b0, 7'($urandom)},
                   8'($urandom));
            end
          end else if (pick < 72) begin
            post({1'b1, 15'($urandom)}, 1'b1, 8'h80 | 8'($urandom), 8'($urandom));
          end else if (pick < 85) begin
            // stray write, may cut a load short
            post(random_address(), 1'b1, 8'($urandom), 8'($urandom));
          end else begin
            post(random_address(), 1'b0, 8'($urandom), 8'($urandom));
          end
        end else begin
          // rom byte often lets the low bits through, so conflicts are not always zero
          rom = ($urandom_range(0, 1) != 0) ? (8'($urandom) | 8'h03) : 8'($urandom);
          if (pick < 45)
            post({1'b1, 15'($urandom)}, 1'b1, 8'($urandom), rom);
          else if (pick < 60)
            post(random_address(), 1'b1, 8'($urandom), rom);
          else
            post(random_address(), 1'b0, 8'($urandom), rom);
        end
      end

      if (phase == 2 || phase == 9) -> start_hold;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && due_mappings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
